// ===== sv/ffpa_pkg.sv =====
// Shared widths, codes and state types of the first-fit page allocator.
`default_nettype none

package ffpa_pkg;

    localparam int OPCODE_W = 2;
    localparam int PAGE_W   = 8;
    localparam int COUNT_W  = 9;
    localparam int TAG_W    = 8;
    localparam int STATUS_W = 2;

    // Page positions and run ends stay below 1024.
    localparam int POS_W      = 10;
    localparam int WORD_BITS  = 8;
    localparam int WORD_SHIFT = 3;
    localparam int WCNT_W     = POS_W - WORD_SHIFT;

    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] REG_PAGES_IN_USE = 2'd0;
    localparam logic [COUNT_W-1:0]    PAGES_IN_USE_RST = 9'd256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_SPACE  = 2'd1,
        STAT_BLOCKED   = 2'd2,
        STAT_UNCHANGED = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_WRITE,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/ffpa_if.sv =====
// Request and response channel interfaces of the page allocator.
`default_nettype none

interface ffpa_req_if
    import ffpa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [PAGE_W-1:0]   start_page;
    logic [COUNT_W-1:0]  page_count;
    logic [COUNT_W-1:0]  new_page_count;
    logic [TAG_W-1:0]    owner_tag;

    modport source (
        output valid, opcode, start_page, page_count, new_page_count, owner_tag,
        input  ready
    );
    modport sink (
        input  valid, opcode, start_page, page_count, new_page_count, owner_tag,
        output ready
    );
endinterface

interface ffpa_rsp_if
    import ffpa_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   result_page;

    modport source (
        output valid, status, result_page,
        input  ready
    );
    modport sink (
        input  valid, status, result_page,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/first_fit_page_allocator.sv =====
// First-fit contiguous page allocator: bitmap and owner store with a word-walking sequencer.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------------
//  req     | in  | valid / ready      | opcode, start_page, page_count, new_page_count,
//          |     |                    | owner_tag
//  rsp     | out | valid / ready      | status, result_page
//  apb     | in  | psel/penable/pready| pages_in_use at byte address 0
//
//  The store is one memory of 8-page words (used bits and owner tags), read through a register.
//  An item walks its words one per cycle: accept, a read of the first word on each pass, then
//  each word scanned or rewritten in turn, then the result register. Allocate scans from
//  page 0 and then rewrites the run.
//  After reset a clearing pass writes NUM_PAGES/8 (rounded up) words before req.ready rises.
//  A finished result waits in the output register; a new item is taken meanwhile, and its
//  result holds in the done state until that register is free.
`default_nettype none

module first_fit_page_allocator
    import ffpa_pkg::*;
#(
    parameter int NUM_PAGES  = 256,
    parameter int OWNER_BITS = 8
) (
    input  wire                   clk,
    input  wire                   rst_n,
    ffpa_req_if.sink              req,
    ffpa_rsp_if.source            rsp,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OWN_W     = WORD_BITS * OWNER_BITS;
    localparam int ENTRY_W   = OWN_W + WORD_BITS;

    // Store: {owner tags, used bits} per word of pages.
    logic [ENTRY_W-1:0] mem [NUM_WORDS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [WA-1:0]      mem_raddr;
    logic [WA-1:0]      mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_we;

    state_t                state_reg, state_next;
    logic [COUNT_W-1:0]    piu_reg;
    logic [WA-1:0]         clr_reg;
    logic [WCNT_W-1:0]     iw_reg, iw_next;
    logic [WCNT_W-1:0]     pw_reg, pw_next;
    logic                  rv_reg, rv_next;
    logic [WCNT_W-1:0]     last_reg, last_next;
    logic [POS_W-1:0]      rs_reg, rs_next;
    logic [POS_W-1:0]      re_reg, re_next;
    logic                  set_reg, set_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [POS_W-1:0]      count_reg, count_next;
    logic [POS_W-1:0]      run_reg, run_next;
    status_t               res_status_reg, res_status_next;
    logic [PAGE_W-1:0]     res_page_reg, res_page_next;
    logic                  out_valid_reg, out_valid_next;
    status_t               out_status_reg, out_status_next;
    logic [PAGE_W-1:0]     out_page_reg, out_page_next;

    logic [POS_W-1:0] lim;
    logic             accept;
    logic             cfg_write;
    logic             clr_last;
    logic             walking;
    logic             leave;
    logic             issue;
    logic             out_free;

    // Decode of an accepted item.
    state_t            dec_state;
    logic [POS_W-1:0]  dec_rs, dec_re;
    logic              dec_set;
    status_t           dec_status;
    logic [PAGE_W-1:0] dec_page;
    logic [WCNT_W-1:0] dec_first, dec_last;

    // Word in flight.
    logic [WORD_BITS-1:0] rd_used;
    logic [OWN_W-1:0]     rd_owner;
    logic [POS_W-1:0]     page_pos [WORD_BITS];
    logic [WORD_BITS-1:0] in_lim, in_rng;
    logic                 scan_hit;
    logic [POS_W-1:0]     scan_run;
    logic [POS_W-1:0]     hit_pos;
    logic [POS_W-1:0]     hit_start;
    logic                 blocked;
    logic [WORD_BITS-1:0] new_used;
    logic [OWN_W-1:0]     new_owner;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == REG_PAGES_IN_USE);
    assign prdata    = (paddr == REG_PAGES_IN_USE) ? APB_DATA_W'(piu_reg) : '0;

    assign lim = (32'(piu_reg) > NUM_PAGES) ? POS_W'(NUM_PAGES) : POS_W'(piu_reg);

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign clr_last  = (32'(clr_reg) == NUM_WORDS - 1);
    assign walking   = (state_reg == ST_SCAN) || (state_reg == ST_CHECK)
                    || (state_reg == ST_WRITE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.result_page = out_page_reg;

    // Item decode: range, initial result and first walk.
    always_comb
    begin : decode
        logic [POS_W-1:0] start_x, count_x, newc_x;
        logic [POS_W-1:0] end_cnt, end_new, clip_cnt;
        logic [POS_W-1:0] last_pos;
        start_x  = POS_W'(req.start_page);
        count_x  = POS_W'(req.page_count);
        newc_x   = POS_W'(req.new_page_count);
        end_cnt  = start_x + count_x;
        end_new  = start_x + newc_x;
        clip_cnt = (end_cnt > lim) ? lim : end_cnt;

        dec_state  = ST_DONE;
        dec_rs     = start_x;
        dec_re     = clip_cnt;
        dec_set    = 1'b0;
        dec_status = STAT_NO_SPACE;
        dec_page   = '0;
        case (req.opcode)
            OP_ALLOC:
            begin
                dec_rs = '0;
                dec_re = lim;
                if ((count_x != '0) && (count_x <= lim))
                begin
                    dec_state = ST_SCAN;
                end
            end
            OP_FREE:
            begin
                dec_status = STAT_OK;
                dec_page   = req.start_page;
                if (start_x < clip_cnt)
                begin
                    dec_state = ST_WRITE;
                end
            end
            OP_RESIZE:
            begin
                if (newc_x < count_x)
                begin
                    dec_rs     = end_new;
                    dec_status = STAT_OK;
                    dec_page   = req.start_page;
                    if (end_new < clip_cnt)
                    begin
                        dec_state = ST_WRITE;
                    end
                end
                else if (newc_x > count_x)
                begin
                    dec_rs  = end_cnt;
                    dec_re  = end_new;
                    dec_set = 1'b1;
                    if (end_new > lim)
                    begin
                        dec_status = STAT_BLOCKED;
                    end
                    else
                    begin
                        dec_status = STAT_OK;
                        dec_page   = req.start_page;
                        dec_state  = ST_CHECK;
                    end
                end
                else
                begin
                    dec_status = STAT_UNCHANGED;
                end
            end
            default:
            begin
                dec_state = ST_DONE;
            end
        endcase
        dec_first = dec_rs[POS_W-1:WORD_SHIFT];
        last_pos  = dec_re - 1'b1;
        dec_last  = last_pos[POS_W-1:WORD_SHIFT];
    end

    // Per-page view of the word that just came out of the store.
    assign rd_used  = rd_data_reg[WORD_BITS-1:0];
    assign rd_owner = rd_data_reg[ENTRY_W-1:WORD_BITS];

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            page_pos[i] = {pw_reg, WORD_SHIFT'(0)} + POS_W'(i);
            in_lim[i]   = page_pos[i] < lim;
            in_rng[i]   = (page_pos[i] >= rs_reg) && (page_pos[i] < re_reg);
        end
    end

    // First-fit run tracking across the word.
    always_comb
    begin : scan_chain
        logic [POS_W-1:0] run;
        logic             found;
        run     = run_reg;
        found   = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (!rd_used[i] && in_lim[i])
            begin
                run = run + 1'b1;
            end
            else
            begin
                run = '0;
            end
            if (!found && (run == count_reg))
            begin
                found   = 1'b1;
                hit_pos = page_pos[i];
            end
        end
        scan_hit = found;
        scan_run = run;
    end

    assign hit_start = hit_pos - count_reg + 1'b1;
    assign blocked   = |(rd_used & in_rng);

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            new_used[i] = in_rng[i] ? set_reg : rd_used[i];
            new_owner[i*OWNER_BITS +: OWNER_BITS] =
                in_rng[i] ? (set_reg ? owner_reg : '0) : rd_owner[i*OWNER_BITS +: OWNER_BITS];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dec_state;
                end
            end
            ST_SCAN:
            begin
                if (rv_reg)
                begin
                    if (scan_hit)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (pw_reg == last_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_CHECK:
            begin
                if (rv_reg)
                begin
                    if (blocked)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (pw_reg == last_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE:
            begin
                if (rv_reg && (pw_reg == last_reg))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign leave = walking && (state_next != state_reg);
    assign issue = walking && (iw_reg <= last_reg) && !leave;

    // Datapath and outputs.
    always_comb
    begin
        iw_next         = iw_reg;
        pw_next         = pw_reg;
        rv_next         = issue;
        last_next       = last_reg;
        rs_next         = rs_reg;
        re_next         = re_reg;
        set_next        = set_reg;
        owner_next      = owner_reg;
        count_next      = count_reg;
        run_next        = run_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_page_next   = out_page_reg;

        if (issue)
        begin
            iw_next = iw_reg + 1'b1;
            pw_next = iw_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rs_next         = dec_rs;
                    re_next         = dec_re;
                    set_next        = dec_set;
                    res_status_next = dec_status;
                    res_page_next   = dec_page;
                    count_next      = POS_W'(req.page_count);
                    owner_next      = OWNER_BITS'({{OWNER_BITS{1'b0}}, req.owner_tag});
                    iw_next         = dec_first;
                    last_next       = dec_last;
                    run_next        = '0;
                end
            end
            ST_SCAN:
            begin
                if (rv_reg)
                begin
                    run_next = scan_run;
                    if (scan_hit)
                    begin
                        rs_next         = hit_start;
                        re_next         = hit_pos + 1'b1;
                        set_next        = 1'b1;
                        res_status_next = STAT_OK;
                        res_page_next   = hit_start[PAGE_W-1:0];
                        iw_next         = hit_start[POS_W-1:WORD_SHIFT];
                        last_next       = hit_pos[POS_W-1:WORD_SHIFT];
                    end
                end
            end
            ST_CHECK:
            begin
                if (rv_reg)
                begin
                    if (blocked)
                    begin
                        res_status_next = STAT_BLOCKED;
                        res_page_next   = '0;
                    end
                    else if (pw_reg == last_reg)
                    begin
                        // rewrite the same words
                        iw_next = rs_reg[POS_W-1:WORD_SHIFT];
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_page_next   = res_page_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Store ports.
    assign mem_raddr = WA'({{WA{1'b0}}, iw_reg});
    assign mem_we    = (state_reg == ST_CLEAR) || ((state_reg == ST_WRITE) && rv_reg);
    assign mem_waddr = (state_reg == ST_CLEAR) ? clr_reg : WA'({{WA{1'b0}}, pw_reg});
    assign mem_wdata = (state_reg == ST_CLEAR) ? '0 : {new_owner, new_used};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            rv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            piu_reg       <= PAGES_IN_USE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rv_reg        <= rv_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_write)
            begin
                piu_reg <= pwdata[COUNT_W-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        iw_reg         <= iw_next;
        pw_reg         <= pw_next;
        last_reg       <= last_next;
        rs_reg         <= rs_next;
        re_reg         <= re_next;
        set_reg        <= set_next;
        owner_reg      <= owner_next;
        count_reg      <= count_next;
        run_reg        <= run_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
    end

endmodule

`default_nettype wire

// ===== dv/first_fit_page_allocator_tb.sv =====
// Self-checking testbench for the first-fit page allocator: directed runs, then random phases.
`default_nettype none

module first_fit_page_allocator_tb
    import ffpa_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_SLOTS     = 256;
    localparam int TAG_BITS       = 8;
    localparam int HANG_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 100;
    localparam int MAX_IDLE       = 7;
    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [PAGE_W-1:0]   start_page;
        logic [COUNT_W-1:0]  page_count;
        logic [COUNT_W-1:0]  new_page_count;
        logic [TAG_W-1:0]    owner_tag;
    } page_req_t;

    typedef struct packed {
        status_t           status;
        logic [PAGE_W-1:0] result_page;
    } page_outcome_t;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } live_run_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ffpa_req_if req_ch ();
    ffpa_rsp_if rsp_ch ();

    first_fit_page_allocator #(
        .NUM_PAGES  (PAGE_SLOTS),
        .OWNER_BITS (TAG_BITS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow page table
    bit                 page_taken [PAGE_SLOTS];
    logic [TAG_W-1:0]   page_tag   [PAGE_SLOTS];
    logic [COUNT_W-1:0] pages_cfg;

    page_req_t     page_requests [$];
    page_outcome_t due_outcomes  [$];
    page_outcome_t last_outcome;
    live_run_t     live_runs     [$];
    event          request_taken;

    bit request_offered;
    int send_gap;
    int take_hold;
    bit no_idle;
    int fail_count;
    int idle_cycles;

    function automatic int unsigned managed_pages();
        return (pages_cfg < PAGE_SLOTS) ? pages_cfg : PAGE_SLOTS;
    endfunction

    function automatic void write_run(int unsigned first, int unsigned len, bit used,
                                      logic [TAG_W-1:0] tag);
        int unsigned lim;
        int unsigned p;
        lim = managed_pages();
        for (int unsigned k = 0; k < len; k++) begin
            p = first + k;
            if (p >= lim)
                break;
            page_taken[p] = used;
            page_tag[p]   = used ? tag : '0;
        end
    endfunction

    function automatic bit run_is_free(int unsigned first, int unsigned len);
        int unsigned lim;
        lim = managed_pages();
        if (first > lim || len > lim - first)
            return 1'b0;
        for (int unsigned k = 0; k < len; k++)
            if (page_taken[first + k])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic page_outcome_t page_table_apply(page_req_t r);
        int unsigned   lim;
        int unsigned   start;
        int unsigned   count;
        int unsigned   newc;
        page_outcome_t o;
        o.status      = STAT_NO_SPACE;
        o.result_page = '0;
        start = 32'(r.start_page);
        count = 32'(r.page_count);
        newc  = 32'(r.new_page_count);
        case (r.opcode)
            OP_ALLOC: begin
                lim = managed_pages();
                if (count != 0 && count <= lim) begin
                    for (int unsigned i = 0; i + count <= lim; i++) begin
                        if (run_is_free(i, count)) begin
                            write_run(i, count, 1'b1, r.owner_tag);
                            o.status      = STAT_OK;
                            o.result_page = PAGE_W'(i);
                            break;
                        end
                    end
                end
            end
            OP_FREE: begin
                write_run(start, count, 1'b0, '0);
                o.status      = STAT_OK;
                o.result_page = r.start_page;
            end
            OP_RESIZE: begin
                if (newc < count) begin
                    write_run(start + newc, count - newc, 1'b0, '0);
                    o.status      = STAT_OK;
                    o.result_page = r.start_page;
                end
                else if (newc > count) begin
                    if (run_is_free(start + count, newc - count)) begin
                        write_run(start + count, newc - count, 1'b1, r.owner_tag);
                        o.status      = STAT_OK;
                        o.result_page = r.start_page;
                    end
                    else begin
                        o.status = STAT_BLOCKED;
                    end
                end
                else begin
                    o.status = STAT_UNCHANGED;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic page_req_t make_req(int unsigned op, int unsigned start,
                                           int unsigned count, int unsigned newc,
                                           int unsigned tag);
        page_req_t r;
        r.opcode         = OPCODE_W'(op);
        r.start_page     = PAGE_W'(start);
        r.page_count     = COUNT_W'(count);
        r.new_page_count = COUNT_W'(newc);
        r.owner_tag      = TAG_W'(tag);
        return r;
    endfunction

    task automatic send_request(input page_req_t r);
        page_requests.push_back(r);
        @(request_taken);
    endtask

    task automatic apb_access(input bit is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        rdata = prdata;
        if (is_write && addr == REG_PAGES_IN_USE)
            pages_cfg = wdata[COUNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_page_limit(input logic [COUNT_W-1:0] value);
        logic [APB_DATA_W-1:0] rd;
        while (due_outcomes.size() != 0 || page_requests.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        apb_access(1'b1, REG_PAGES_IN_USE, APB_DATA_W'(value), rd);
        apb_access(1'b0, REG_PAGES_IN_USE, '0, rd);
        if (rd[COUNT_W-1:0] !== value) begin
            $error("pages_in_use: expected %0d, got %0d", value, rd[COUNT_W-1:0]);
            fail_count++;
        end
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] limit_value, input int items);
        int unsigned lim;
        int unsigned pick;
        int unsigned cnt;
        int unsigned newc;
        int          k;
        live_run_t   rn;
        set_page_limit(limit_value);
        live_runs.delete();
        lim = (limit_value < PAGE_SLOTS) ? limit_value : PAGE_SLOTS;
        for (int n = 0; n < items; n++) begin
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                send_request(make_req($urandom_range(0, 3), $urandom_range(0, 255),
                                      $urandom_range(0, 511), $urandom_range(0, 511),
                                      $urandom_range(0, 255)));
            end
            else if (live_runs.size() == 0 || (pick < 45 && live_runs.size() < 24)) begin
                pick = $urandom_range(0, 99);
                if (lim == 0 || pick < 70)
                    cnt = $urandom_range(1, 8);
                else if (pick < 90)
                    cnt = $urandom_range(1, lim / 4 + 1);
                else if (pick < 95)
                    cnt = lim;
                else
                    cnt = $urandom_range(0, 511);
                send_request(make_req(OP_ALLOC, $urandom_range(0, 255), cnt,
                                      $urandom_range(0, 511), $urandom_range(0, 255)));
                if (last_outcome.status == STAT_OK) begin
                    rn.first = last_outcome.result_page;
                    rn.len   = cnt;
                    live_runs.push_back(rn);
                end
            end
            else if (pick < 72) begin
                k  = $urandom_range(0, live_runs.size() - 1);
                rn = live_runs[k];
                send_request(make_req(OP_FREE, rn.first, rn.len, $urandom_range(0, 511),
                                      $urandom_range(0, 255)));
                live_runs.delete(k);
            end
            else begin
                k    = $urandom_range(0, live_runs.size() - 1);
                rn   = live_runs[k];
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    newc = $urandom_range(0, rn.len - 1);
                else if (pick < 50)
                    newc = rn.len;
                else if (pick < 90)
                    newc = rn.len + $urandom_range(1, 8);
                else
                    newc = $urandom_range(rn.len + 1, 511);
                send_request(make_req(OP_RESIZE, rn.first, rn.len, newc,
                                      $urandom_range(0, 255)));
                if (last_outcome.status == STAT_OK) begin
                    if (newc == 0)
                        live_runs.delete(k);
                    else
                        live_runs[k].len = newc;
                end
            end
        end
        // clear the managed range before the limit moves
        send_request(make_req(OP_FREE, 0, 511, 0, 0));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Request driver
    always @(negedge clk)
    begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
        end
        else if (!request_offered) begin
            if (page_requests.size() == 0) begin
                req_ch.valid <= 1'b0;
            end
            else if (send_gap != 0) begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else begin
                req_ch.opcode         <= page_requests[0].opcode;
                req_ch.start_page     <= page_requests[0].start_page;
                req_ch.page_count     <= page_requests[0].page_count;
                req_ch.new_page_count <= page_requests[0].new_page_count;
                req_ch.owner_tag      <= page_requests[0].owner_tag;
                req_ch.valid          <= 1'b1;
                request_offered = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready) begin
            last_outcome = page_table_apply(page_requests[0]);
            due_outcomes.push_back(last_outcome);
            request_offered = 1'b0;
            send_gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            page_requests.pop_front();
            -> request_taken;
        end
    end

    // Result monitor
    always @(negedge clk)
    begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
        end
        else if (take_hold != 0) begin
            take_hold--;
            rsp_ch.ready <= 1'b0;
        end
        else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        page_outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (due_outcomes.size() == 0) begin
                $error("unexpected transfer: status %0d, result_page %0d",
                       rsp_ch.status, rsp_ch.result_page);
                fail_count++;
            end
            else begin
                want = due_outcomes.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fail_count++;
                end
                if (rsp_ch.result_page !== want.result_page) begin
                    $error("result_page: expected %0d, got %0d",
                           want.result_page, rsp_ch.result_page);
                    fail_count++;
                end
            end
            take_hold = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        end
    end

    // Watchdog: any transfer on a channel or the register port restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable && pready)) begin
            idle_cycles = 0;
        end
        else begin
            idle_cycles++;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        req_ch.valid          = 1'b0;
        req_ch.opcode         = '0;
        req_ch.start_page     = '0;
        req_ch.page_count     = '0;
        req_ch.new_page_count = '0;
        req_ch.owner_tag      = '0;
        rsp_ch.ready          = 1'b0;
        pages_cfg             = PAGES_IN_USE_RST;
        request_offered       = 1'b0;
        send_gap              = 0;
        take_hold             = 0;
        no_idle               = 1'b0;
        fail_count            = 0;
        idle_cycles           = 0;
        for (int p = 0; p < PAGE_SLOTS; p++) begin
            page_taken[p] = 1'b0;
            page_tag[p]   = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_page_limit(9'd256);

        send_request(make_req(OP_ALLOC, 0, 0, 0, 8'h00));         // zero length
        send_request(make_req(OP_ALLOC, 0, 257, 0, 8'h00));       // longer than the table
        send_request(make_req(OP_ALLOC, 0, 256, 0, 8'hFF));       // whole table
        send_request(make_req(OP_ALLOC, 0, 1, 0, 8'h01));         // table full
        send_request(make_req(OP_FREE, 0, 256, 0, 8'h00));
        send_request(make_req(OP_ALLOC, 8'hFF, 3, 0, 8'hA5));
        send_request(make_req(OP_ALLOC, 0, 5, 0, 8'h5A));
        send_request(make_req(OP_FREE, 0, 3, 0, 8'h00));
        send_request(make_req(OP_ALLOC, 0, 2, 0, 8'h0F));         // fits the first hole
        send_request(make_req(OP_ALLOC, 0, 2, 0, 8'hF0));         // skips the one-page hole
        send_request(make_req(OP_RESIZE, 3, 5, 5, 8'h00));        // same length
        send_request(make_req(OP_RESIZE, 3, 5, 7, 8'h00));        // grow into a taken page
        send_request(make_req(OP_RESIZE, 8, 2, 6, 8'h33));        // grow into free pages
        send_request(make_req(OP_RESIZE, 3, 5, 0, 8'h00));        // shrink to nothing
        send_request(make_req(OP_FREE, 250, 100, 0, 8'h00));      // runs off the end
        send_request(make_req(OP_FREE, 100, 4, 0, 8'h00));        // pages already free
        send_request(make_req(OP_RESIZE, 250, 4, 10, 8'h00));     // grow off the end
        send_request(make_req(OP_RESIZE, 0, 2, 1, 8'h00));
        send_request(make_req(OP_RESIZE, 8, 6, 511, 8'hC3));
        send_request(make_req(OP_RESERVED, 8'h80, 9'h1FF, 9'h1FF, 8'hFF));
        send_request(make_req(OP_ALLOC, 0, 511, 0, 8'h00));
        send_request(make_req(OP_FREE, 0, 511, 0, 8'h00));

        run_phase(9'd1, 60);
        run_phase(9'd0, 40);
        run_phase(9'd511, 275);
        run_phase(9'd40, 275);
        run_phase(9'd256, 275);
        run_phase(9'd9, 275);
        run_phase(9'd200, 275);
        run_phase(9'd256, 275);

        while (due_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== first_fit_page_allocator.f =====
sv/ffpa_pkg.sv
sv/ffpa_if.sv
sv/first_fit_page_allocator.sv
dv/first_fit_page_allocator_tb.sv
